// ----- src/lagrange_cubic_interpolator_defines.svh -----
// Assertion macros used by the interpolator's top level.
`ifndef LAGRANGE_CUBIC_INTERPOLATOR_DEFINES_SVH
`define LAGRANGE_CUBIC_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define LCI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lci: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define LCI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lci: next-cycle check failed");

`endif

// ----- src/lci_pkg.sv -----
// Shared types, codes and constants of the Lagrange interpolator.
package lci_pkg;

    localparam int NUM_NODES  = 6;
    localparam int WIN_SIZE   = 4;
    localparam int NODE_IDX_W = 3;
    localparam int VAL_W      = 24;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_COINCIDENT = 2'd1;
    localparam logic [1:0] ST_SATURATED  = 2'd2;

    localparam logic [39:0] WEIGHT_CAP = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic                    command;
        logic [NODE_IDX_W-1:0]   node_index;
        logic signed [VAL_W-1:0] node_x;
        logic signed [VAL_W-1:0] node_y;
        logic signed [VAL_W-1:0] query_x;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [1:0]              window_first;
        logic [1:0]              status;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_START, OP_SCAN, OP_FIRST, OP_WIN, OP_DIFF,
        OP_MUL01, OP_RND, OP_MULL, OP_MULH, OP_ACCH, OP_SAVE,
        OP_DIVINIT, OP_DIVSTEP, OP_TSET, OP_TERM, OP_RESULT
    } dp_op_t;

    typedef enum logic [1:0] {
        SRC_NUM, SRC_DEN, SRC_TERM
    } src_t;

    typedef struct packed {
        dp_op_t                op;
        src_t                  src;
        logic [1:0]            k;
        logic [NODE_IDX_W-1:0] node_sel;
        logic [1:0]            widx;
        logic                  d_shift;
    } dp_cmd_t;

    typedef struct packed {
        logic coincident;
        logic div_skip;
    } dp_stat_t;

    function automatic logic signed [VAL_W-1:0] reset_x(input int i);
        logic signed [VAL_W-1:0] v;
        case (i)
            0: v = 24'sd26214;
            1: v = 24'sd36045;
            2: v = 24'sd42598;
            3: v = 24'sd52429;
            4: v = 24'sd58982;
            5: v = 24'sd68813;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [VAL_W-1:0] reset_y(input int i);
        logic signed [VAL_W-1:0] v;
        case (i)
            0: v = 24'sd26919;
            1: v = 24'sd37890;
            2: v = 24'sd45662;
            3: v = 24'sd58203;
            4: v = 24'sd67274;
            5: v = 24'sd82170;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/lci_stream_if.sv -----
// Valid/ready stream interface carrying one payload per beat.
interface lci_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/lagrange_cubic_interpolator.sv -----
// Top level of the four-point Lagrange interpolator over a six-node table.
//
//  Channel    Direction  Payload                                         Beat meaning
//  in_chan    sink       command, node_index, node_x, node_y, query_x   one command
//  out_chan   source     result_value, window_first, status              one result
//
// A load command's result beat is offered on the next cycle. An evaluate command scans
// the table and fetches the window, then per window node runs two three-factor
// products on the shared 24 x 24 multiplier, a 40-step restoring divide and a term.
// The divider dominates; it is skipped when a weight is zero or clamped.
// Reset restores the node table to its default nodes at once; no clearing pass.
// A new command is taken only while no command is in flight and the output register
// is free or being emptied in the same cycle, so a stalled result holds the block.
module lagrange_cubic_interpolator
    import lci_pkg::*;
#(
    parameter int NUM_NODES = lci_pkg::NUM_NODES
) (
    input  logic         clk,
    input  logic         rst_n,
    lci_stream_if.sink   in_chan,
    lci_stream_if.source out_chan
);

`include "lagrange_cubic_interpolator_defines.svh"

    // Commands run from the controller to the datapath; status runs back.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    lci_ctrl #(
        .NUM_NODES (NUM_NODES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_chan.valid),
        .in_command (in_chan.payload.command),
        .in_ready   (in_chan.ready),
        .out_valid  (out_chan.valid),
        .out_ready  (out_chan.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // The datapath owns the node table and the result register.
    lci_datapath #(
        .NUM_NODES (NUM_NODES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_item  (in_chan.payload),
        .stat     (stat),
        .out_item (out_chan.payload)
    );

    // A command is only taken when the result register can receive its beat.
    `LCI_ASSERT_NOW(a_in_free, in_chan.ready, !out_chan.valid || out_chan.ready)
    // A load answers on the very next cycle.
    `LCI_ASSERT_NEXT(a_load_rsp, in_chan.valid && in_chan.ready && in_chan.payload.command == CMD_LOAD, out_chan.valid)
    // Coincident nodes give a zero value.
    `LCI_ASSERT_NOW(a_coin_zero, out_chan.valid && out_chan.payload.status == ST_COINCIDENT, out_chan.payload.result_value == '0)
    // The window starts at the first node or at the last possible start.
    `LCI_ASSERT_NOW(a_first, out_chan.valid, out_chan.payload.window_first == 2'd0 || out_chan.payload.window_first == 2'(NUM_NODES - WIN_SIZE))

endmodule

// ----- src/lci_ctrl.sv -----
// Sequencing state machine of the interpolator.
module lci_ctrl
    import lci_pkg::*;
#(
    parameter int NUM_NODES = lci_pkg::NUM_NODES
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_command,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_FIRST, S_WIN, S_DIFF, S_CHK,
        S_MUL01, S_RND, S_MULL, S_MULH, S_ACCH, S_SAVE,
        S_DIVINIT, S_DIVCHK, S_DIVSTEP, S_TSET, S_TERM, S_RESULT
    } state_t;

    localparam int DIV_STEPS = 40;

    state_t     state_reg, state_next;
    src_t       ph_reg, ph_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] k_reg, k_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '{op: OP_NONE, src: ph_reg, k: k_reg,
                           node_sel: cnt_reg[NODE_IDX_W-1:0], widx: cnt_reg[1:0],
                           d_shift: (cnt_reg < 6'd7)};
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_command == CMD_LOAD)
                    begin
                        cmd.op         = OP_LOAD;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmd.op     = OP_START;
                        cnt_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (cnt_reg == 6'(NUM_NODES - 1))
                begin
                    state_next = S_FIRST;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_FIRST:
            begin
                cmd.op     = OP_FIRST;
                cnt_next   = '0;
                state_next = S_WIN;
            end
            S_WIN:
            begin
                cmd.op = OP_WIN;
                if (cnt_reg == 6'(WIN_SIZE - 1))
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.coincident)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    k_next     = '0;
                    ph_next    = SRC_NUM;
                    state_next = S_MUL01;
                end
            end
            S_MUL01:
            begin
                cmd.op     = OP_MUL01;
                state_next = S_RND;
            end
            S_RND:
            begin
                cmd.op     = OP_RND;
                state_next = S_MULL;
            end
            S_MULL:
            begin
                cmd.op     = OP_MULL;
                state_next = S_MULH;
            end
            S_MULH:
            begin
                cmd.op     = OP_MULH;
                state_next = S_ACCH;
            end
            S_ACCH:
            begin
                cmd.op     = OP_ACCH;
                state_next = (ph_reg == SRC_TERM) ? S_TERM : S_SAVE;
            end
            S_SAVE:
            begin
                cmd.op = OP_SAVE;
                if (ph_reg == SRC_NUM)
                begin
                    ph_next    = SRC_DEN;
                    state_next = S_MUL01;
                end
                else
                begin
                    state_next = S_DIVINIT;
                end
            end
            S_DIVINIT:
            begin
                cmd.op     = OP_DIVINIT;
                cnt_next   = '0;
                state_next = S_DIVCHK;
            end
            S_DIVCHK:
            begin
                state_next = stat.div_skip ? S_TSET : S_DIVSTEP;
            end
            S_DIVSTEP:
            begin
                cmd.op = OP_DIVSTEP;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    state_next = S_TSET;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_TSET:
            begin
                cmd.op     = OP_TSET;
                ph_next    = SRC_TERM;
                state_next = S_MULL;
            end
            S_TERM:
            begin
                cmd.op = OP_TERM;
                if (k_reg == 2'(WIN_SIZE - 1))
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    ph_next    = SRC_NUM;
                    state_next = S_MUL01;
                end
            end
            S_RESULT:
            begin
                cmd.op         = OP_RESULT;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= SRC_NUM;
            cnt_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/lci_datapath.sv -----
// Node table, shared multiplier, restoring divider and accumulator.
module lci_datapath
    import lci_pkg::*;
#(
    parameter int NUM_NODES = lci_pkg::NUM_NODES
) (
    input  logic      clk,
    input  logic      rst_n,
    input  dp_cmd_t   cmd,
    input  in_item_t  in_item,
    output dp_stat_t  stat,
    output out_item_t out_item
);

    logic signed [VAL_W-1:0] x_reg [NUM_NODES];
    logic signed [VAL_W-1:0] y_reg [NUM_NODES];

    logic signed [VAL_W-1:0] q_reg;
    logic [NODE_IDX_W-1:0]   station_reg;
    logic [NODE_IDX_W-1:0]   first_reg;
    logic signed [VAL_W-1:0] wx_reg [WIN_SIZE];
    logic signed [VAL_W-1:0] wy_reg [WIN_SIZE];
    logic signed [VAL_W:0]   qd_reg [WIN_SIZE];
    logic signed [VAL_W:0]   dd_reg [6];
    logic                    coin_reg;
    logic [47:0]             p_reg;
    logic [39:0]             t_reg;
    logic [63:0]             acc_reg;
    logic [63:0]             num_reg;
    logic [63:0]             den_reg;
    logic [71:0]             r_reg;
    logic [71:0]             dv_reg;
    logic [39:0]             w_reg;
    logic                    skip_reg;
    logic signed [35:0]      sum_reg;
    logic                    sat_reg;
    out_item_t               res_reg;

    logic [VAL_W-1:0] qmag [WIN_SIZE];
    logic [VAL_W-1:0] dmag [6];
    logic [VAL_W-1:0] fac  [3];
    logic [VAL_W-1:0] ymag;
    logic [VAL_W-1:0] mul_a, mul_b;
    logic             neg_k;
    logic             ge;
    logic [71:0]      r_sub;
    logic [64:0]      t_round;
    logic [NODE_IDX_W-1:0] win_addr;

    function automatic logic [VAL_W-1:0] mag25(input logic signed [VAL_W:0] v);
        logic [VAL_W:0] a;
        a = v[VAL_W] ? -v : v;
        return a[VAL_W-1:0];
    endfunction

    function automatic logic [2:0] pair_idx(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] p;
        case ({a, b})
            4'b0001: p = 3'd0;
            4'b0010: p = 3'd1;
            4'b0011: p = 3'd2;
            4'b0110: p = 3'd3;
            4'b0111: p = 3'd4;
            4'b1011: p = 3'd5;
            default: p = 3'd0;
        endcase
        return p;
    endfunction

    assign win_addr = first_reg + NODE_IDX_W'(cmd.widx);
    assign stat     = '{coincident: coin_reg, div_skip: skip_reg};
    assign out_item = res_reg;
    assign ge       = r_reg >= dv_reg;
    assign r_sub    = ge ? (r_reg - dv_reg) : r_reg;
    assign t_round  = {1'b0, acc_reg} + 65'h0_8000_0000;

    // Factors of the current window node: the three others in ascending order, plus its y magnitude and term sign.
    always_comb
    begin
        logic [1:0] j;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            qmag[i] = mag25(qd_reg[i]);
        end
        for (int i = 0; i < 6; i++)
        begin
            dmag[i] = mag25(dd_reg[i]);
        end
        for (int f = 0; f < 3; f++)
        begin
            j = (2'(f) < cmd.k) ? 2'(f) : 2'(f + 1);
            if (cmd.src == SRC_DEN)
            begin
                fac[f] = (j < cmd.k) ? dmag[pair_idx(j, cmd.k)] : dmag[pair_idx(cmd.k, j)];
            end
            else
            begin
                fac[f] = qmag[j];
            end
        end
        ymag  = mag25({wy_reg[cmd.k][VAL_W-1], wy_reg[cmd.k]});
        neg_k = wy_reg[cmd.k][VAL_W-1];
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            if (2'(i) != cmd.k)
            begin
                neg_k = neg_k ^ qd_reg[i][VAL_W];
                if (2'(i) > cmd.k)
                begin
                    neg_k = neg_k ^ dd_reg[pair_idx(cmd.k, 2'(i))][VAL_W];
                end
                else
                begin
                    neg_k = neg_k ^ !dd_reg[pair_idx(2'(i), cmd.k)][VAL_W];
                end
            end
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL01:
            begin
                mul_a = fac[0];
                mul_b = fac[1];
            end
            OP_MULL:
            begin
                mul_a = t_reg[23:0];
                mul_b = (cmd.src == SRC_TERM) ? ymag : fac[2];
            end
            OP_MULH:
            begin
                mul_a = {8'b0, t_reg[39:24]};
                mul_b = (cmd.src == SRC_TERM) ? ymag : fac[2];
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_NODES; i++)
            begin
                x_reg[i] <= reset_x(i);
                y_reg[i] <= reset_y(i);
            end
        end
        else if (cmd.op == OP_LOAD && in_item.node_index < NODE_IDX_W'(NUM_NODES))
        begin
            x_reg[in_item.node_index] <= in_item.node_x;
            y_reg[in_item.node_index] <= in_item.node_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_MUL01 || cmd.op == OP_MULL || cmd.op == OP_MULH)
        begin
            p_reg <= mul_a * mul_b;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                res_reg <= '{result_value: '0, window_first: '0, status: ST_OK};
            end
            OP_START:
            begin
                q_reg       <= in_item.query_x;
                station_reg <= '0;
            end
            OP_SCAN:
            begin
                if (q_reg > x_reg[cmd.node_sel])
                begin
                    station_reg <= cmd.node_sel;
                end
            end
            OP_FIRST:
            begin
                first_reg <= (station_reg <= NODE_IDX_W'(2)) ? '0
                             : NODE_IDX_W'(NUM_NODES - WIN_SIZE);
            end
            OP_WIN:
            begin
                wx_reg[cmd.widx] <= x_reg[win_addr];
                wy_reg[cmd.widx] <= y_reg[win_addr];
            end
            OP_DIFF:
            begin
                for (int i = 0; i < WIN_SIZE; i++)
                begin
                    qd_reg[i] <= {q_reg[VAL_W-1], q_reg} - {wx_reg[i][VAL_W-1], wx_reg[i]};
                end
                dd_reg[0] <= {wx_reg[0][VAL_W-1], wx_reg[0]} - {wx_reg[1][VAL_W-1], wx_reg[1]};
                dd_reg[1] <= {wx_reg[0][VAL_W-1], wx_reg[0]} - {wx_reg[2][VAL_W-1], wx_reg[2]};
                dd_reg[2] <= {wx_reg[0][VAL_W-1], wx_reg[0]} - {wx_reg[3][VAL_W-1], wx_reg[3]};
                dd_reg[3] <= {wx_reg[1][VAL_W-1], wx_reg[1]} - {wx_reg[2][VAL_W-1], wx_reg[2]};
                dd_reg[4] <= {wx_reg[1][VAL_W-1], wx_reg[1]} - {wx_reg[3][VAL_W-1], wx_reg[3]};
                dd_reg[5] <= {wx_reg[2][VAL_W-1], wx_reg[2]} - {wx_reg[3][VAL_W-1], wx_reg[3]};
                coin_reg  <= (wx_reg[0] == wx_reg[1]) || (wx_reg[0] == wx_reg[2])
                          || (wx_reg[0] == wx_reg[3]) || (wx_reg[1] == wx_reg[2])
                          || (wx_reg[1] == wx_reg[3]) || (wx_reg[2] == wx_reg[3]);
                sum_reg   <= '0;
                sat_reg   <= 1'b0;
            end
            OP_RND:
            begin
                t_reg <= 40'(({1'b0, p_reg} + 49'd128) >> 8);
            end
            OP_MULH:
            begin
                acc_reg <= {16'b0, p_reg};
            end
            OP_ACCH:
            begin
                acc_reg <= 64'({8'b0, acc_reg} + {p_reg, 24'b0});
            end
            OP_SAVE:
            begin
                if (cmd.src == SRC_NUM)
                begin
                    num_reg <= acc_reg;
                end
                else
                begin
                    den_reg <= acc_reg;
                end
            end
            OP_DIVINIT:
            begin
                r_reg  <= {8'b0, num_reg};
                dv_reg <= {1'b0, den_reg, 7'b0};
                if (num_reg == '0)
                begin
                    skip_reg <= 1'b1;
                    w_reg    <= '0;
                end
                else if ({8'b0, num_reg} >= {den_reg, 8'b0})
                begin
                    skip_reg <= 1'b1;
                    w_reg    <= WEIGHT_CAP;
                    if (wy_reg[cmd.k] != '0)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                else
                begin
                    skip_reg <= 1'b0;
                    w_reg    <= '0;
                end
            end
            OP_DIVSTEP:
            begin
                w_reg <= {w_reg[38:0], ge};
                if (cmd.d_shift)
                begin
                    r_reg  <= r_sub;
                    dv_reg <= dv_reg >> 1;
                end
                else
                begin
                    r_reg <= {r_sub[70:0], 1'b0};
                end
            end
            OP_TSET:
            begin
                t_reg <= w_reg;
            end
            OP_TERM:
            begin
                if (neg_k)
                begin
                    sum_reg <= sum_reg - signed'({3'b0, t_round[64:32]});
                end
                else
                begin
                    sum_reg <= sum_reg + signed'({3'b0, t_round[64:32]});
                end
            end
            OP_RESULT:
            begin
                res_reg.window_first <= first_reg[1:0];
                if (coin_reg)
                begin
                    res_reg.result_value <= '0;
                    res_reg.status       <= ST_COINCIDENT;
                end
                else if (sum_reg > 36'sd8388607)
                begin
                    res_reg.result_value <= 24'sh7FFFFF;
                    res_reg.status       <= ST_SATURATED;
                end
                else if (sum_reg < -36'sd8388608)
                begin
                    res_reg.result_value <= 24'sh800000;
                    res_reg.status       <= ST_SATURATED;
                end
                else
                begin
                    res_reg.result_value <= sum_reg[VAL_W-1:0];
                    res_reg.status       <= sat_reg ? ST_SATURATED : ST_OK;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule
